[rtl/hdtp_pkg.sv]
// ----------------------------------------------------------------------------
// hdtp_pkg
// Shared constants, item type, atan table and shift helper for the turn-limited heading block.
// ----------------------------------------------------------------------------
package hdtp_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int NSTEP        = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int STEP_W       = 5;

	// x/y datapath width: normalized magnitude below 2^41, cordic gain and
	// the first rotation keep it below 2^43
	localparam int XY_W = 46;
	localparam int NM_W = 41;
	localparam int SH_W = 6;

	// shift by 32,16,8,4,2,1 while below the limit, then one fixed shift
	localparam int NORM_CELLS = 7;

	// input stage, pre-rotation stage, normalizer, cordic, two limit stages
	localparam int LAT = 2 + NORM_CELLS + NSTEP + 2;

	localparam logic [NM_W-1:0] NORM_LIM     = NM_W'(64'h100_0000_0000);
	localparam logic [14:0]     MAX_TURN_RST = 15'd5461;
	localparam logic [31:0]     Z_PI         = 32'h8000_0000;
	localparam logic [31:0]     ROUND_HALF   = 32'h0000_8000;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [NM_W-1:0]        m;
		logic [31:0]            z;
		logic                   zero;
		logic [15:0]            head;
	} hdtp_item_t;

	// atan(2^-i) with 2^31 = pi
	function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2F9;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic [SH_W-1:0] norm_shift(input int k);
		int s;
		s = (k < NORM_CELLS - 1) ? (32 >> k) : 1;
		return SH_W'(s);
	endfunction

endpackage

[rtl/hdtp_norm_cell.sv]
// ----------------------------------------------------------------------------
// hdtp_norm_cell
// One normalizer cell: shifts the vector left when the magnitude stays small, or always in the fixed-shift cell.
// ----------------------------------------------------------------------------
module hdtp_norm_cell import hdtp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [SH_W-1:0] sh,
	input  logic            fixed_sh,
	input  logic            vld_in,
	input  hdtp_item_t      d_in,
	output logic            vld_out,
	output hdtp_item_t      d_out
);

	logic       take;
	hdtp_item_t nxt;
	hdtp_item_t d_q;
	logic       vld_q;

	always_comb begin
		take = fixed_sh || (d_in.m < (NORM_LIM >> sh));
		nxt  = d_in;
		if (take) begin
			nxt.x = d_in.x <<< sh;
			nxt.y = d_in.y <<< sh;
			nxt.m = d_in.m << sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign vld_out = vld_q;
	assign d_out   = d_q;

endmodule

[rtl/hdtp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// hdtp_cordic_cell
// One vectoring step: rotates toward the x axis and updates the angle.
// ----------------------------------------------------------------------------
module hdtp_cordic_cell import hdtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  logic              vld_in,
	input  hdtp_item_t        d_in,
	output logic              vld_out,
	output hdtp_item_t        d_out
);

	logic signed [XY_W-1:0] x_in;
	logic signed [XY_W-1:0] y_in;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic [31:0]            ang;
	hdtp_item_t             nxt;
	hdtp_item_t             d_q;
	logic                   vld_q;

	always_comb begin
		x_in = d_in.x;
		y_in = d_in.y;
		xs   = x_in >>> step;
		ys   = y_in >>> step;
		ang  = atan_lut(step);
		nxt  = d_in;
		// zero y rotates the same way as positive y
		if (y_in[XY_W-1]) begin
			nxt.x = x_in - ys;
			nxt.y = y_in + xs;
			nxt.z = d_in.z - ang;
		end else begin
			nxt.x = x_in + ys;
			nxt.y = y_in - xs;
			nxt.z = d_in.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nxt;
	end

	assign vld_out = vld_q;
	assign d_out   = d_q;

endmodule

[rtl/hdtp_limit.sv]
// ----------------------------------------------------------------------------
// hdtp_limit
// Rounds the bearing, wraps the heading error and applies the turn limit.
// ----------------------------------------------------------------------------
module hdtp_limit import hdtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_in,
	input  logic [31:0] z,
	input  logic        zero,
	input  logic [15:0] head,
	input  logic [14:0] max_turn,
	output logic        done,
	output logic [15:0] heading_cmd,
	output logic        turn_clamped
);

	logic [31:0] rnd;
	logic [15:0] b;
	logic [15:0] b_s1;
	logic [15:0] diff_s1;
	logic [15:0] head_s1;
	logic        vld_s1;
	logic        neg;
	logic [15:0] adiff;
	logic [15:0] lim;
	logic        clamp;
	logic [15:0] cmd;
	logic [15:0] cmd_s2;
	logic        clamp_s2;
	logic        vld_s2;

	always_comb begin
		rnd = z + ROUND_HALF;
		b   = zero ? 16'd0 : rnd[31:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		b_s1    <= b;
		diff_s1 <= b - head;
		head_s1 <= head;
	end

	// a difference of exactly pi has magnitude 32768 and turns negative
	always_comb begin
		neg   = diff_s1[15];
		adiff = neg ? (16'd0 - diff_s1) : diff_s1;
		lim   = {1'b0, max_turn};
		clamp = adiff > lim;
		cmd   = b_s1;
		if (clamp) begin
			cmd = neg ? (head_s1 - lim) : (head_s1 + lim);
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2   <= cmd;
		clamp_s2 <= clamp;
	end

	assign done         = vld_s2;
	assign heading_cmd  = cmd_s2;
	assign turn_clamped = clamp_s2;

	a_vld_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done)
		else $error("limit stage lost a transaction");

	a_no_extra_done: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |=> !done)
		else $error("limit stage produced an extra transaction");

	a_clamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && turn_clamped |->
			(heading_cmd == $past(head_s1) + {1'b0, max_turn}) ||
			(heading_cmd == $past(head_s1) - {1'b0, max_turn}))
		else $error("clamped command is not heading plus or minus the limit");

endmodule

[rtl/heading_toward_point_turn_limited.sv]
// ----------------------------------------------------------------------------
// heading_toward_point_turn_limited
// Bearing to a target point by a pipelined cordic, limited to a turn step.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         start & !busy        here_x, here_y, heading_now,
//                                            goal_x, goal_y
//  result    out        done (one cycle)     heading_cmd, turn_clamped
//  config    in         cfg_valid&cfg_ready  cfg_data (max_turn)
//
//  one request per cycle while not busy; every result follows its request
//  through the input and pre-rotation stages, 7 normalizer cells, 16 cordic
//  cells and two limit stages.
//  busy is high only while in reset and the cycle after; results cannot be
//  stalled, so the pipeline never holds.
//  reset sets max_turn to 5461 and clears all valid bits.
// ----------------------------------------------------------------------------
module heading_toward_point_turn_limited import hdtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] here_x,
	input  logic [31:0] here_y,
	input  logic [15:0] heading_now,
	input  logic [31:0] goal_x,
	input  logic [31:0] goal_y,
	output logic        done,
	output logic [15:0] heading_cmd,
	output logic        turn_clamped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	logic        rdy_q;
	logic [14:0] max_turn_q;
	logic        accept;

	logic signed [33:0] dx_s1;
	logic signed [33:0] dy_s1;
	logic [15:0]        head_s1;
	logic               vld_s1;

	logic signed [33:0] ax;
	logic signed [33:0] ay;
	logic signed [33:0] ry;
	logic               xneg;
	hdtp_item_t         pre;
	hdtp_item_t         item_s2;
	logic               vld_s2;

	hdtp_item_t nrm_d [NORM_CELLS+1];
	logic       nrm_v [NORM_CELLS+1];
	hdtp_item_t cor_d [NSTEP+1];
	logic       cor_v [NSTEP+1];

	assign accept    = start && !busy;
	assign busy      = !rdy_q;
	assign cfg_ready = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q      <= 1'b0;
			max_turn_q <= MAX_TURN_RST;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
		end else begin
			rdy_q  <= 1'b1;
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			if (cfg_valid && cfg_ready) begin
				max_turn_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {{2{goal_x[31]}}, goal_x} - {{2{here_x[31]}}, here_x};
		dy_s1   <= {{2{goal_y[31]}}, goal_y} - {{2{here_y[31]}}, here_y};
		head_s1 <= heading_now;
	end

	// left half plane: negate the vector and start the angle at pi
	always_comb begin
		xneg = dx_s1[33];
		ax   = xneg ? -dx_s1 : dx_s1;
		ay   = dy_s1[33] ? -dy_s1 : dy_s1;
		ry   = xneg ? -dy_s1 : dy_s1;
		pre.x    = {{(XY_W-34){ax[33]}}, ax};
		pre.y    = {{(XY_W-34){ry[33]}}, ry};
		pre.m    = (ax > ay) ? NM_W'(ax) : NM_W'(ay);
		pre.z    = xneg ? Z_PI : 32'd0;
		pre.zero = (dx_s1 == 34'sd0) && (dy_s1 == 34'sd0);
		pre.head = head_s1;
	end

	always_ff @(posedge clk) begin
		item_s2 <= pre;
	end

	assign nrm_d[0] = item_s2;
	assign nrm_v[0] = vld_s2;

	for (genvar k = 0; k < NORM_CELLS; k++) begin : g_norm
		hdtp_norm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.sh       (norm_shift(k)),
			.fixed_sh (k == NORM_CELLS - 1),
			.vld_in   (nrm_v[k]),
			.d_in     (nrm_d[k]),
			.vld_out  (nrm_v[k+1]),
			.d_out    (nrm_d[k+1])
		);
	end

	assign cor_d[0] = nrm_d[NORM_CELLS];
	assign cor_v[0] = nrm_v[NORM_CELLS];

	for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
		hdtp_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (STEP_W'(i)),
			.vld_in  (cor_v[i]),
			.d_in    (cor_d[i]),
			.vld_out (cor_v[i+1]),
			.d_out   (cor_d[i+1])
		);
	end

	hdtp_limit u_limit (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld_in       (cor_v[NSTEP]),
		.z            (cor_d[NSTEP].z),
		.zero         (cor_d[NSTEP].zero),
		.head         (cor_d[NSTEP].head),
		.max_turn     (max_turn_q),
		.done         (done),
		.heading_cmd  (heading_cmd),
		.turn_clamped (turn_clamped)
	);

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result does not follow its transaction after the pipeline latency");

	a_no_orphan_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching transaction");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !vld_s1)
		else $error("transaction entered the pipeline while busy");

endmodule

[bench/heading_toward_point_turn_limited_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_toward_point_turn_limited_tb
// Self-checking bench for the turn-limited bearing block: directed corner
// items, limit register extremes and randomized requests, each result
// compared against a bit-exact cordic and turn-limit predictor.
// ----------------------------------------------------------------------------
module heading_toward_point_turn_limited_tb;

	localparam int    PIPE_LAT   = 27;
	localparam int    WDOG_LIMIT = 2000;
	localparam int    ROT_STEPS  = 16;
	localparam int    ATAN_LEN   = 24;
	localparam longint NORM_MIN  = 64'sd1 << 40;
	localparam logic [14:0] LIMIT_RST = 15'd5461;

	// atan(2^-i), 2^31 = pi
	localparam logic [31:0] ATAN_ROM [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [15:0] heading_cmd;
		logic        turn_clamped;
	} heading_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] here_x;
	logic [31:0] here_y;
	logic [15:0] heading_now;
	logic [31:0] goal_x;
	logic [31:0] goal_y;
	logic        done;
	logic [15:0] heading_cmd;
	logic        turn_clamped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [14:0] cfg_data;

	heading_result_t cmd_expect_q[$];
	logic [14:0]     turn_limit_q;
	bit              no_idle;
	int              errors;
	int              requests_sent;
	int              results_seen;
	int              clamps_seen;
	int              limit_writes;
	int              quiet_cycles;

	heading_toward_point_turn_limited dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.here_x       (here_x),
		.here_y       (here_y),
		.heading_now  (heading_now),
		.goal_x       (goal_x),
		.goal_y       (goal_y),
		.done         (done),
		.heading_cmd  (heading_cmd),
		.turn_clamped (turn_clamped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// bearing of goal seen from here, 16-bit binary angle
	function automatic logic [15:0] bearing_of(input logic [31:0] hx, input logic [31:0] hy,
			input logic [31:0] gx, input logic [31:0] gy);
		longint      x;
		longint      y;
		longint      xs;
		longint      ys;
		logic [31:0] z;
		logic [31:0] zr;
		x = longint'($signed(gx)) - longint'($signed(hx));
		y = longint'($signed(gy)) - longint'($signed(hy));
		z = 32'h0;
		if (x == 0 && y == 0)
			return 16'h0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		while ((x < 0 ? -x : x) < NORM_MIN && (y < 0 ? -y : y) < NORM_MIN) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < ROT_STEPS && i < ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_ROM[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_ROM[i];
			end
		end
		zr = z + 32'h0000_8000;
		return zr[31:16];
	endfunction

	function automatic heading_result_t predict_command(input logic [31:0] hx,
			input logic [31:0] hy, input logic [15:0] hd, input logic [31:0] gx,
			input logic [31:0] gy);
		heading_result_t  r;
		logic [15:0]      b;
		logic signed [15:0] diff;
		int               adiff;
		b = bearing_of(hx, hy, gx, gy);
		diff = $signed(b - hd);
		adiff = (diff < 0) ? -int'(diff) : int'(diff);
		r.heading_cmd = b;
		r.turn_clamped = 1'b0;
		if (adiff > int'(turn_limit_q)) begin
			r.turn_clamped = 1'b1;
			// exactly pi has a negative code and turns the negative way
			if (diff > 0)
				r.heading_cmd = hd + {1'b0, turn_limit_q};
			else
				r.heading_cmd = hd - {1'b0, turn_limit_q};
		end
		return r;
	endfunction

	task automatic send_request(input logic [31:0] hx, input logic [31:0] hy,
			input logic [15:0] hd, input logic [31:0] gx, input logic [31:0] gy);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		here_x <= hx;
		here_y <= hy;
		heading_now <= hd;
		goal_x <= gx;
		goal_y <= gy;
		do
			@(posedge clk);
		while (busy);
		cmd_expect_q.push_back(predict_command(hx, hy, hd, gx, gy));
		requests_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (cmd_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_turn_limit(input logic [14:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= 15'($urandom);
		turn_limit_q = value;
		limit_writes++;
	endtask

	task automatic send_random_request();
		logic [31:0]        hx;
		logic [31:0]        hy;
		logic [31:0]        gx;
		logic [31:0]        gy;
		logic [31:0]        dxr;
		logic [31:0]        dyr;
		logic [15:0]        hd;
		logic signed [15:0] off;
		int                 kind;
		kind = $urandom_range(0, 9);
		hx = $urandom;
		hy = $urandom;
		if (kind < 3) begin
			gx = $urandom;
			gy = $urandom;
		end else begin
			// short offsets of every size exercise the normalizer
			dxr = $signed($urandom) >>> $urandom_range(0, 31);
			dyr = $signed($urandom) >>> $urandom_range(0, 31);
			if (kind == 9) begin
				if ($urandom_range(0, 1))
					dxr = 32'h0;
				else
					dyr = 32'h0;
				if ($urandom_range(0, 3) == 0) begin
					dxr = 32'h0;
					dyr = 32'h0;
				end
			end
			gx = hx + dxr;
			gy = hy + dyr;
		end
		if ($urandom_range(0, 1)) begin
			off = 16'($urandom);
			off = off >>> $urandom_range(0, 15);
			hd = bearing_of(hx, hy, gx, gy) - off;
		end else begin
			hd = 16'($urandom);
		end
		send_request(hx, hy, hd, gx, gy);
	endtask

	task automatic test_default_limit();
		no_idle = 1'b0;
		// zero vector
		send_request(32'd123, 32'd456, 16'd0, 32'd123, 32'd456);
		send_request(32'hDEAD_BEEF, 32'h1234_5678, 16'd20000, 32'hDEAD_BEEF, 32'h1234_5678);
		// the four axes
		send_request(32'd0, 32'd0, 16'd0, 32'h0001_0000, 32'd0);
		send_request(32'd0, 32'd0, 16'd0, 32'hFFFF_0000, 32'd0);
		send_request(32'd0, 32'd0, 16'h8000, 32'hFFFF_0000, 32'd0);
		send_request(32'd0, 32'd0, 16'h4000, 32'd0, 32'h0001_0000);
		send_request(32'd0, 32'd0, 16'hC000, 32'd0, 32'hFFFF_0000);
		// largest differences
		send_request(32'h8000_0000, 32'd0, 16'd0, 32'h7FFF_FFFF, 32'd0);
		send_request(32'h7FFF_FFFF, 32'h8000_0000, 16'h6000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hA000, 32'h8000_0000, 32'h8000_0000);
		// one-lsb vectors
		send_request(32'd0, 32'd0, 16'hE000, 32'd1, 32'hFFFF_FFFF);
		send_request(32'd0, 32'd0, 16'h6000, 32'hFFFF_FFFF, 32'd1);
		// command wraps past +pi and past -pi
		send_request(32'd0, 32'd0, 16'h7FFF, 32'd0, 32'hFFFF_0000);
		send_request(32'd0, 32'd0, 16'h8000, 32'd0, 32'h0001_0000);
		// difference right at the limit and one past it
		send_request(32'd0, 32'd0, 16'd5461, 32'h0001_0000, 32'd0);
		send_request(32'd0, 32'd0, -16'sd5462, 32'h0001_0000, 32'd0);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0);
		drain_results();
	endtask

	task automatic test_limit_extremes();
		no_idle = 1'b1;
		write_turn_limit(15'd0);
		send_request(32'd0, 32'd0, 16'd0, 32'h0001_0000, 32'd0);
		send_request(32'd0, 32'd0, 16'd1, 32'h0001_0000, 32'd0);
		send_request(32'd0, 32'd0, 16'hFFFF, 32'h0001_0000, 32'd0);
		drain_results();
		write_turn_limit(15'h7FFF);
		// a difference of pi is clamped even at the widest limit
		send_request(32'd0, 32'd0, 16'd0, 32'hFFFF_0000, 32'd0);
		send_request(32'd0, 32'd0, 16'h8001, 32'h0001_0000, 32'd0);
		send_request(32'd0, 32'd0, 16'h7FFF, 32'h0001_0000, 32'd0);
		drain_results();
	endtask

	task automatic test_random_mixed();
		logic [14:0] lim;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: lim = LIMIT_RST;
				1: lim = 15'd0;
				2: lim = 15'h7FFF;
				3: lim = 15'd1;
				4: lim = 15'h7FFE;
				7: lim = 15'h4000;
				default: lim = 15'($urandom_range(0, 32767));
			endcase
			write_turn_limit(lim);
			for (int n = 0; n < 88; n++) begin
				if (n % 22 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				send_random_request();
			end
			drain_results();
		end
	endtask

	// result checker
	always @(posedge clk) begin
		heading_result_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (turn_clamped)
				clamps_seen++;
			if (cmd_expect_q.size() == 0) begin
				$display("%0t ERROR unexpected result heading_cmd %0d clamped %0b",
					$time, $signed(heading_cmd), turn_clamped);
				errors++;
			end else begin
				exp_r = cmd_expect_q.pop_front();
				if (heading_cmd !== exp_r.heading_cmd) begin
					$display("%0t ERROR heading_cmd expected %0d actual %0d", $time,
						$signed(exp_r.heading_cmd), $signed(heading_cmd));
					errors++;
				end
				if (turn_clamped !== exp_r.turn_clamped) begin
					$display("%0t ERROR turn_clamped expected %0b actual %0b", $time,
						exp_r.turn_clamped, turn_clamped);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("%0t watchdog expired with %0d results pending", $time,
					cmd_expect_q.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		requests_sent = 0;
		limit_writes = 0;
		turn_limit_q = LIMIT_RST;
		no_idle = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		here_x <= 32'h0;
		here_y <= 32'h0;
		heading_now <= 16'h0;
		goal_x <= 32'h0;
		goal_y <= 32'h0;
		cfg_valid <= 1'b0;
		cfg_data <= 15'h0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_limit();
		test_limit_extremes();
		test_random_mixed();

		drain_results();
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (cmd_expect_q.size() != 0)
			$display("%0t ERROR %0d results never arrived", $time, cmd_expect_q.size());
		$display("run covered %0d requests and %0d results (%0d clamped)",
			requests_sent, results_seen, clamps_seen);
		$display("turn limit written %0d times, extremes included; %0d mismatches",
			limit_writes, errors);
		if (errors == 0 && cmd_expect_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
